// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the fragmenter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked while out of reset.
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every edge, reset included.
`define ASSERT_ANY(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define ASSERT_ANY(lbl, clk, prop, msg)
`endif
`endif

// ===== rtl/core/hnrf_pkg.sv =====
// Types and constants of the NAL to RTP fragmenter.
`timescale 1ns / 1ps
`default_nettype none
package hnrf_pkg;

  localparam int unsigned POS_W   = 24;
  localparam int unsigned LEN_W   = 16;
  localparam int unsigned NLEN_W  = 32;
  localparam logic [POS_W-1:0] FRAME_BYTES_MAX = 24'hFFFFFF;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_CODEC_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PREFIX_LEN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD = 2'd2;

  localparam logic [2:0]  PREFIX_LEN_RESET  = 3'd4;
  localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd1200;

  // Codec and header codes
  localparam logic       CODEC_H264      = 1'b0;
  localparam logic [4:0] NAL_TYPE_FILLER = 5'd12;
  localparam logic [4:0] FU_A_TYPE       = 5'd28;
  localparam logic [5:0] HEVC_FU_TYPE    = 6'd49;
  localparam logic [7:0] NRI_MASK        = 8'hE0;
  localparam logic [1:0] HDR_CNT_SINGLE  = 2'd0;
  localparam logic [1:0] HDR_CNT_FU_A    = 2'd2;
  localparam logic [1:0] HDR_CNT_HEVC_FU = 2'd3;
  localparam logic       KIND_PACKET     = 1'b0;
  localparam logic       KIND_OVERRUN    = 1'b1;

  // Queue between parser and formatter
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_AW    = $clog2(Q_DEPTH);
  localparam int unsigned Q_CW    = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic       codec_mode;
    logic [2:0] length_prefix_bytes;
    logic [15:0] max_payload;
  } cfg_t;

  typedef struct packed {
    logic [7:0]       data_byte;
    logic [POS_W-1:0] frame_size;
    logic             frame_last;
  } in_item_t;

  typedef struct packed {
    logic             result_kind;
    logic [POS_W-1:0] payload_offset;
    logic [LEN_W-1:0] payload_length;
    logic [1:0]       header_count;
    logic [7:0]       header_first;
    logic [7:0]       header_second;
    logic [7:0]       header_third;
  } out_item_t;

  // Classified event from the parser
  typedef struct packed {
    logic             is_err;
    logic             is_fu;
    logic             h265;
    logic             first;
    logic             last;
    logic [POS_W-1:0] offset;
    logic [LEN_W-1:0] length;
    logic [7:0]       hdr1;
    logic [7:0]       hdr2;
  } ev_t;

endpackage
`default_nettype wire

// ===== rtl/core/hnrf_front.sv =====
// Byte parser: walks length prefixes and NAL units and classifies events.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module hnrf_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire hnrf_pkg::in_item_t in_data,
  input  wire hnrf_pkg::cfg_t  cfg,
  input  wire logic            q_full,
  output logic                 push,
  output hnrf_pkg::ev_t        push_data
);
  import hnrf_pkg::*;

  typedef enum logic [4:0] {
    PH_PREFIX = 5'b00001,
    PH_HEAD1  = 5'b00010,
    PH_HEAD2  = 5'b00100,
    PH_BODY   = 5'b01000,
    PH_SKIP   = 5'b10000
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [NLEN_W-1:0]   acc_r, acc_nxt;
  logic [2:0]          seen_r, seen_nxt;
  logic [NLEN_W-1:0]   left_r, left_nxt;
  logic [7:0]          h1_r, h1_nxt;
  logic [7:0]          h2_r, h2_nxt;
  logic [POS_W-1:0]    start_r, start_nxt;
  logic [LEN_W-1:0]    fill_r, fill_nxt;
  logic                first_r, first_nxt;
  logic                frag_r, frag_nxt;
  logic                discard_r, discard_nxt;

  logic                accept;
  logic                res;
  ev_t                 ev;
  logic [2:0]          plen;
  logic [1:0]          hb;
  logic [1:0]          hc;
  logic [LEN_W-1:0]    cap;
  logic [POS_W:0]      pos_inc;
  logic [POS_W-1:0]    pos_p1;
  logic [POS_W-1:0]    span;
  logic [NLEN_W-1:0]   acc_sh;
  logic [2:0]          seen_inc;
  logic [NLEN_W-1:0]   left_dec;
  logic [NLEN_W-1:0]   left_sat;
  logic [LEN_W-1:0]    fill_inc;
  logic                short_tail;
  logic                overrun;

  assign accept   = in_valid && !q_full;
  assign in_stall = q_full;

  always_comb begin
    if (cfg.length_prefix_bytes == 3'd0) begin
      plen = 3'd1;
    end else if (cfg.length_prefix_bytes > 3'd4) begin
      plen = 3'd4;
    end else begin
      plen = cfg.length_prefix_bytes;
    end
  end

  assign hb  = (cfg.codec_mode == CODEC_H264) ? 2'd1 : 2'd2;
  assign hc  = (cfg.codec_mode == CODEC_H264) ? 2'd2 : 2'd3;
  assign cap = (cfg.max_payload > {14'd0, hc}) ? (cfg.max_payload - {14'd0, hc})
                                               : 16'd1;

  assign pos_inc  = {1'b0, pos_r} + {{POS_W{1'b0}}, 1'b1};
  assign pos_p1   = pos_inc[POS_W-1:0];
  assign span     = pos_p1 - start_r;
  assign acc_sh   = {acc_r[NLEN_W-9:0], in_data.data_byte};
  assign seen_inc = seen_r + 3'd1;
  assign left_dec = left_r - 32'd1;
  assign left_sat = (left_r != '0) ? left_dec : '0;
  assign fill_inc = fill_r + 16'd1;

  // Prefix cannot fit with its NAL: ignore the tail of the frame
  assign short_tail = ({2'b00, in_data.frame_size} <= ({2'b00, pos_r} + {23'd0, plen}));
  assign overrun    = ({8'd0, pos_inc} + {1'b0, acc_sh}) > {9'd0, in_data.frame_size};

  always_comb begin
    phase_nxt   = phase_r;
    pos_nxt     = pos_r;
    acc_nxt     = acc_r;
    seen_nxt    = seen_r;
    left_nxt    = left_r;
    h1_nxt      = h1_r;
    h2_nxt      = h2_r;
    start_nxt   = start_r;
    fill_nxt    = fill_r;
    first_nxt   = first_r;
    frag_nxt    = frag_r;
    discard_nxt = discard_r;
    res         = 1'b0;
    ev          = '0;
    ev.h265     = cfg.codec_mode;

    if (!discard_r) begin
      case (phase_r)
        PH_PREFIX: begin
          if (seen_r == 3'd0 && short_tail) begin
            discard_nxt = 1'b1;
          end else if (seen_inc >= plen) begin
            acc_nxt  = '0;
            seen_nxt = 3'd0;
            if (overrun) begin
              res         = 1'b1;
              ev.is_err   = 1'b1;
              discard_nxt = 1'b1;
            end else if (acc_sh == '0) begin
              res       = 1'b1;
              ev.offset = pos_p1;
            end else begin
              left_nxt  = acc_sh;
              start_nxt = pos_p1;
              fill_nxt  = '0;
              first_nxt = 1'b1;
              frag_nxt  = (acc_sh > {16'd0, cfg.max_payload}) &&
                          (acc_sh > {30'd0, hb});
              phase_nxt = PH_HEAD1;
            end
          end else begin
            acc_nxt  = acc_sh;
            seen_nxt = seen_inc;
          end
        end
        PH_HEAD1: begin
          h1_nxt   = in_data.data_byte;
          left_nxt = left_dec;
          if (cfg.codec_mode == CODEC_H264 &&
              in_data.data_byte[4:0] == NAL_TYPE_FILLER) begin
            // drop filler NAL
            phase_nxt = (left_dec != '0) ? PH_SKIP : PH_PREFIX;
          end else if (frag_r) begin
            start_nxt = pos_p1;
            fill_nxt  = '0;
            if (left_dec == '0) begin
              phase_nxt = PH_PREFIX;
            end else if (cfg.codec_mode == CODEC_H264) begin
              phase_nxt = PH_BODY;
            end else begin
              phase_nxt = PH_HEAD2;
            end
          end else if (left_dec == '0) begin
            res       = 1'b1;
            ev.offset = start_r;
            ev.length = span[LEN_W-1:0];
            phase_nxt = PH_PREFIX;
          end else begin
            phase_nxt = PH_BODY;
          end
        end
        PH_HEAD2: begin
          h2_nxt    = in_data.data_byte;
          left_nxt  = left_dec;
          start_nxt = pos_p1;
          fill_nxt  = '0;
          phase_nxt = (left_dec != '0) ? PH_BODY : PH_PREFIX;
        end
        PH_BODY: begin
          left_nxt = left_sat;
          if (frag_r) begin
            if (fill_inc >= cap || left_sat == '0) begin
              res       = 1'b1;
              ev.is_fu  = 1'b1;
              ev.first  = first_r;
              ev.last   = (left_sat == '0);
              ev.offset = start_r;
              ev.length = fill_inc;
              ev.hdr1   = h1_r;
              ev.hdr2   = h2_r;
              first_nxt = 1'b0;
              start_nxt = start_r + {8'd0, fill_inc};
              fill_nxt  = '0;
            end else begin
              fill_nxt = fill_inc;
            end
          end else if (left_sat == '0) begin
            res       = 1'b1;
            ev.offset = start_r;
            ev.length = span[LEN_W-1:0];
          end
          if (left_sat == '0) begin
            phase_nxt = PH_PREFIX;
          end
        end
        PH_SKIP: begin
          left_nxt = left_sat;
          if (left_sat == '0) begin
            phase_nxt = PH_PREFIX;
          end
        end
        default: begin
          phase_nxt = PH_PREFIX;
        end
      endcase
    end

    if (in_data.frame_last) begin
      // restart per-frame state
      phase_nxt   = PH_PREFIX;
      pos_nxt     = '0;
      acc_nxt     = '0;
      seen_nxt    = 3'd0;
      left_nxt    = '0;
      h1_nxt      = '0;
      h2_nxt      = '0;
      start_nxt   = '0;
      fill_nxt    = '0;
      first_nxt   = 1'b1;
      frag_nxt    = 1'b0;
      discard_nxt = 1'b0;
    end else if (pos_r != FRAME_BYTES_MAX) begin
      pos_nxt = pos_p1;
    end
  end

  assign push      = accept && res;
  assign push_data = ev;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_PREFIX;
      pos_r     <= '0;
      acc_r     <= '0;
      seen_r    <= 3'd0;
      left_r    <= '0;
      h1_r      <= '0;
      h2_r      <= '0;
      start_r   <= '0;
      fill_r    <= '0;
      first_r   <= 1'b1;
      frag_r    <= 1'b0;
      discard_r <= 1'b0;
    end else if (accept) begin
      phase_r   <= phase_nxt;
      pos_r     <= pos_nxt;
      acc_r     <= acc_nxt;
      seen_r    <= seen_nxt;
      left_r    <= left_nxt;
      h1_r      <= h1_nxt;
      h2_r      <= h2_nxt;
      start_r   <= start_nxt;
      fill_r    <= fill_nxt;
      first_r   <= first_nxt;
      frag_r    <= frag_nxt;
      discard_r <= discard_nxt;
    end
  end

  `ASSERT_RST(a_discard_silent, clk, rst_n, discard_r |-> !push, "event while discarding frame")
  `ASSERT_RST(a_err_discards, clk, rst_n, (push && push_data.is_err && !in_data.frame_last) |=> discard_r, "overrun did not start discard")

endmodule
`default_nettype wire

// ===== rtl/core/hnrf_queue.sv =====
// Short event queue between the parser and the formatter.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module hnrf_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire hnrf_pkg::ev_t push_data,
  output logic               full,
  input  wire logic          pop,
  output logic               pop_valid,
  output hnrf_pkg::ev_t      pop_data
);
  import hnrf_pkg::*;

  localparam logic [Q_CW-1:0] CNT_FULL = Q_CW'(Q_DEPTH);
  localparam logic [Q_CW-1:0] CNT_ONE  = Q_CW'(1);

  ev_t             slots_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0] cnt_r, cnt_nxt;
  logic            do_push;
  logic            do_pop;

  assign full      = (cnt_r == CNT_FULL);
  assign pop_valid = (cnt_r != '0);
  assign pop_data  = slots_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + Q_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + Q_AW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_ONE;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  `ASSERT_RST(a_cnt_bound, clk, rst_n, cnt_r <= CNT_FULL, "queue count beyond depth")
  `ASSERT_RST(a_cnt_grow, clk, rst_n, (do_push && !do_pop) |=> (cnt_r == $past(cnt_r) + CNT_ONE), "queue count did not grow on push")
  `ASSERT_ANY(a_cnt_reset, clk, !rst_n |=> (cnt_r == '0), "queue not empty after reset")

endmodule
`default_nettype wire

// ===== rtl/core/hnrf_back.sv =====
// Formatter: builds descriptors and FU headers, holds the output register.
`timescale 1ns / 1ps
`default_nettype none
module hnrf_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid,
  input  wire hnrf_pkg::ev_t q_data,
  output logic               q_pop,
  output logic               out_valid,
  input  wire logic          out_stall,
  output hnrf_pkg::out_item_t out_data
);
  import hnrf_pkg::*;

  out_item_t  out_r, out_nxt;
  logic       out_valid_r;
  logic       load;
  logic [1:0] flags;
  logic [5:0] hevc_type;

  assign load  = q_valid && (!out_valid_r || !out_stall);
  assign q_pop = load;

  assign flags     = {q_data.first, q_data.last};
  assign hevc_type = q_data.hdr1[6:1];

  always_comb begin
    out_nxt = '0;
    if (q_data.is_err) begin
      out_nxt.result_kind = KIND_OVERRUN;
    end else begin
      out_nxt.result_kind    = KIND_PACKET;
      out_nxt.payload_offset = q_data.offset;
      out_nxt.payload_length = q_data.length;
      if (q_data.is_fu) begin
        if (q_data.h265) begin
          // keep F, LayerId and TID; type becomes the FU type
          out_nxt.header_count  = HDR_CNT_HEVC_FU;
          out_nxt.header_first  = {q_data.hdr1[7], HEVC_FU_TYPE, q_data.hdr1[0]};
          out_nxt.header_second = q_data.hdr2;
          out_nxt.header_third  = {flags, hevc_type};
        end else begin
          out_nxt.header_count  = HDR_CNT_FU_A;
          out_nxt.header_first  = (q_data.hdr1 & NRI_MASK) | {3'd0, FU_A_TYPE};
          out_nxt.header_second = {flags, 1'b0, q_data.hdr1[4:0]};
        end
      end else begin
        out_nxt.header_count = HDR_CNT_SINGLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

// ===== rtl/core/h26x_nal_rtp_fragmenter_top.sv =====
// Top level of the H.264/H.265 NAL to RTP packet descriptor fragmenter.
`timescale 1ns / 1ps
`default_nettype none
// Takes one byte of a length-prefixed access unit per clock and returns packet
// descriptors (offset, length, FU header bytes) or an overrun error, at most one
// per byte. A byte is taken every cycle while the four-entry event queue has
// room; a result goes via the event queue to the output register. The parser,
// the event queue and the output register each stall on their own, so out_stall
// only throttles input once the queue fills. Configuration is to be written
// through cfg_we/cfg_index/cfg_wdata while idle; the block does not enforce it.
module h26x_nal_rtp_fragmenter_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire hnrf_pkg::in_item_t            in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output hnrf_pkg::out_item_t                out_data,
  input  wire logic                          cfg_we,
  input  wire logic [hnrf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [hnrf_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import hnrf_pkg::*;

  cfg_t cfg_r;
  logic q_full;
  logic push;
  ev_t  push_data;
  logic q_pop;
  logic q_valid;
  ev_t  q_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.codec_mode          <= CODEC_H264;
      cfg_r.length_prefix_bytes <= PREFIX_LEN_RESET;
      cfg_r.max_payload         <= MAX_PAYLOAD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CODEC_MODE:  cfg_r.codec_mode          <= cfg_wdata[0];
        CFG_PREFIX_LEN:  cfg_r.length_prefix_bytes <= cfg_wdata[2:0];
        CFG_MAX_PAYLOAD: cfg_r.max_payload         <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  hnrf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg       (cfg_r),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  hnrf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_data)
  );

  hnrf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
